// File: rtl/core/lookahead_peak_limiter_top_assert.svh
// Assertion macros for the look-ahead peak limiter.
// Included by the top level; no other dependencies.
`ifndef LOOKAHEAD_PEAK_LIMITER_TOP_ASSERT_SVH
`define LOOKAHEAD_PEAK_LIMITER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define LPL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define LPL_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/lpl_pkg.sv
// Shared types, constants and gain tables of the look-ahead peak limiter.
// No dependencies.
package lpl_pkg;

   localparam int MAX_DELAY_DEF = 256;
   localparam int SAMPLE_W      = 16;
   localparam int WIDE_W        = 20;
   localparam int ENV_W         = 24;
   localparam int GAIN_W        = 17;
   localparam int MUL_W         = 26;
   localparam int PROD_W        = 2 * MUL_W;
   localparam int CSR_ADDR_W    = 5;
   localparam int CSR_DATA_W    = 32;

   localparam logic [GAIN_W-1:0] UNITY_GAIN = 17'h10000;

   typedef enum logic [2:0] {
      CSR_ENABLE    = 3'd0,
      CSR_THRESHOLD = 3'd1,
      CSR_SLOPE     = 3'd2,
      CSR_MAKEUP    = 3'd3,
      CSR_BALANCE   = 3'd4,
      CSR_ATTACK    = 3'd5,
      CSR_RELEASE   = 3'd6,
      CSR_DELAY     = 3'd7
   } csr_index_type;

   // log2 of 1 + i/16, Q.16
   function automatic logic [16:0] log_tab(input logic [4:0] idx);
      logic [16:0] val;
      case (idx)
         5'd0:    val = 17'd0;
         5'd1:    val = 17'd5732;
         5'd2:    val = 17'd11136;
         5'd3:    val = 17'd16248;
         5'd4:    val = 17'd21098;
         5'd5:    val = 17'd25711;
         5'd6:    val = 17'd30109;
         5'd7:    val = 17'd34312;
         5'd8:    val = 17'd38336;
         5'd9:    val = 17'd42196;
         5'd10:   val = 17'd45904;
         5'd11:   val = 17'd49472;
         5'd12:   val = 17'd52911;
         5'd13:   val = 17'd56228;
         5'd14:   val = 17'd59434;
         5'd15:   val = 17'd62534;
         5'd16:   val = 17'd65536;
         default: val = 17'd65536;
      endcase
      return val;
   endfunction

   // 2^(-i/16), Q.16
   function automatic logic [16:0] exp_tab(input logic [4:0] idx);
      logic [16:0] val;
      case (idx)
         5'd0:    val = 17'd65536;
         5'd1:    val = 17'd62757;
         5'd2:    val = 17'd60097;
         5'd3:    val = 17'd57549;
         5'd4:    val = 17'd55109;
         5'd5:    val = 17'd52773;
         5'd6:    val = 17'd50535;
         5'd7:    val = 17'd48393;
         5'd8:    val = 17'd46341;
         5'd9:    val = 17'd44376;
         5'd10:   val = 17'd42495;
         5'd11:   val = 17'd40693;
         5'd12:   val = 17'd38968;
         5'd13:   val = 17'd37316;
         5'd14:   val = 17'd35734;
         5'd15:   val = 17'd34219;
         5'd16:   val = 17'd32768;
         default: val = 17'd32768;
      endcase
      return val;
   endfunction

endpackage

// File: rtl/core/lpl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lpl_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 256
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/lookahead_peak_limiter_top.sv
// Top level of the stereo look-ahead peak limiter: sequencer, shared multiplier, CSRs.
// Depends on lpl_pkg, lpl_ram and lookahead_peak_limiter_top_assert.svh.
//
//   channel   direction   fields
//   req_      in  stream  tdata: sample_left [15:0], sample_right [31:16]
//   rsp_      out stream  tdata: out_left [15:0], out_right [31:16]
//   csr_      APB         8 registers at 4*i, 32-bit data
//
// Enabled: the sequencer computes the gain (two log2 normalizations and the exp2 step)
// only with the envelope above threshold and a negative slope; every product goes
// through the one 26x26 multiplier, one product a cycle. Disabled: samples pass
// unchanged. Reset and a write of 0 to enable start a clearing pass over the delay
// memory; no request is taken during it. A finished result waits in the output
// register while the next request is taken; it holds only when a second one is ready.
`include "lookahead_peak_limiter_top_assert.svh"
module lookahead_peak_limiter_top #(
   parameter int MAX_DELAY = lpl_pkg::MAX_DELAY_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [31:0]                      req_tdata,   // sample_left, sample_right
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [31:0]                      rsp_tdata,   // out_left, out_right
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [lpl_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [lpl_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [lpl_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
   localparam int LW = ($clog2(MAX_DELAY + 1) > 9) ? $clog2(MAX_DELAY + 1) : 9;
   localparam int MW = lpl_pkg::MUL_W;
   localparam int PW = lpl_pkg::PROD_W;
   localparam int VW = lpl_pkg::WIDE_W;
   localparam logic [LW-1:0] MAX_LEN   = LW'(MAX_DELAY);
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_DELAY - 1);
   localparam logic [2:0]    NORM_LAST = 3'd4;

   typedef enum logic [4:0] {
      ST_IDLE, ST_MUL_XL, ST_MUL_XR, ST_MUL_BL, ST_MUL_BR, ST_WB_VR, ST_PEAK,
      ST_ENV_A, ST_ENV_B, ST_ENV_W, ST_CHECK, ST_NORM, ST_LOG_M, ST_LOG_W,
      ST_EXP_E, ST_EXP_EW, ST_EXP_M, ST_EXP_W, ST_GAIN_A, ST_GAIN_B, ST_GAIN_W,
      ST_DLY_M, ST_DLY_W, ST_SQ_M, ST_SQ_W, ST_CUBE_M, ST_CUBE_W, ST_CLIP_M,
      ST_CLIP_W, ST_OUT
   } state_type;

   function automatic logic signed [PW-1:0] rnd_sh(input logic signed [PW-1:0] v,
                                                   input logic [5:0] s);
      logic signed [PW-1:0] half;
      half = PW'(52'sd1) <<< (s - 6'd1);
      return (v + half) >>> s;
   endfunction

   // registers
   state_type                   state_ff, state_in;
   logic                        enable_ff, enable_in;
   logic [15:0]                 thr_ff, thr_in;
   logic signed [15:0]          slope_ff, slope_in;
   logic [15:0]                 makeup_ff, makeup_in;
   logic signed [15:0]          bal_ff, bal_in;
   logic [23:0]                 attack_ff, attack_in;
   logic [23:0]                 release_ff, release_in;
   logic [8:0]                  delay_ff, delay_in;
   logic signed [15:0]          xl_ff, xl_in, xr_ff, xr_in;
   logic signed [20:0]          sl_ff, sl_in, sr_ff, sr_in;
   logic signed [VW-1:0]        vl_ff, vl_in, vr_ff, vr_in;
   logic [24:0]                 m5_ff, m5_in;
   logic [23:0]                 coef_ff, coef_in;
   logic signed [PW-1:0]        acc_ff, acc_in;
   logic signed [PW-1:0]        prod_ff, prod_in;
   logic [23:0]                 env_ff, env_in;
   logic [16:0]                 gain_ff, gain_in;
   logic [23:0]                 norm_ff, norm_in;
   logic [4:0]                  p_ff, p_in;
   logic [2:0]                  step_ff, step_in;
   logic                        pass_ff, pass_in;
   logic [20:0]                 loge_ff, loge_in;
   logic [20:0]                 d_ff, d_in;
   logic [21:0]                 e_ff, e_in;
   logic [16:0]                 target_ff, target_in;
   logic                        ch_ff, ch_in;
   logic signed [20:0]          r_ff, r_in;
   logic signed [18:0]          r2_ff, r2_in, r3_ff, r3_in;
   logic signed [15:0]          yl_ff, yl_in, yr_ff, yr_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [31:0]                 rsp_data_ff, rsp_data_in;
   logic [AW-1:0]               pos_ff, pos_in;
   logic                        clr_busy_ff, clr_busy_in;
   logic [AW-1:0]               clr_addr_ff, clr_addr_in;

   // datapath helpers
   logic signed [MW-1:0]        mul_a, mul_b;
   logic signed [PW-1:0]        prod_r12, prod_r15, prod_r16;
   logic signed [PW-1:0]        env_sum, gain_sum, e_sum, y_wide;
   logic signed [VW-1:0]        v_sat, dly_sample;
   logic [16:0]                 gain_l, gain_r, neg_slope;
   logic [15:0]                 thr1;
   logic [23:0]                 thr_q;
   logic [19:0]                 abs_l, abs_r, max_abs;
   logic [24:0]                 inv_coef;
   logic [16:0]                 log_lo, log_hi;
   logic [20:0]                 log_val;
   logic [5:0]                  e_n;
   logic [16:0]                 exp_lo, exp_hi, tgt0;
   logic signed [15:0]          y_val;
   logic [LW-1:0]               len_eff, pos_inc;
   logic [AW-1:0]               pos_next;
   logic                        csr_wr;
   lpl_pkg::csr_index_type      csr_idx;
   logic                        req_fire;
   logic                        ram_wr_en, ram_rd_en;
   logic [AW-1:0]               ram_wr_addr;
   logic [2*VW-1:0]             ram_wr_data, ram_rd_data;

   // handshake and config decode
   assign req_tready = (state_ff == ST_IDLE) && !clr_busy_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = lpl_pkg::csr_index_type'(csr_paddr[4:2]);

   // read back
   always_comb begin
      case (csr_idx)
         lpl_pkg::CSR_ENABLE:    csr_prdata = {31'd0, enable_ff};
         lpl_pkg::CSR_THRESHOLD: csr_prdata = {16'd0, thr_ff};
         lpl_pkg::CSR_SLOPE:     csr_prdata = {16'd0, slope_ff};
         lpl_pkg::CSR_MAKEUP:    csr_prdata = {16'd0, makeup_ff};
         lpl_pkg::CSR_BALANCE:   csr_prdata = {16'd0, bal_ff};
         lpl_pkg::CSR_ATTACK:    csr_prdata = {8'd0, attack_ff};
         lpl_pkg::CSR_RELEASE:   csr_prdata = {8'd0, release_ff};
         lpl_pkg::CSR_DELAY:     csr_prdata = {23'd0, delay_ff};
         default:                csr_prdata = '0;
      endcase
   end

   // derived operands
   assign gain_l    = (bal_ff > 16'sd0) ? 17'd32768 - 17'(bal_ff) : 17'd32768;
   assign gain_r    = (bal_ff < 16'sd0) ? 17'd32768 + 17'(bal_ff) : 17'd32768;
   assign neg_slope = 17'(-(17'(slope_ff)));
   assign thr1      = (thr_ff == 16'd0) ? 16'd1 : thr_ff;
   assign thr_q     = 24'({thr1, 5'd0});
   assign abs_l     = vl_ff[VW-1] ? 20'(-vl_ff) : 20'(vl_ff);
   assign abs_r     = vr_ff[VW-1] ? 20'(-vr_ff) : 20'(vr_ff);
   assign max_abs   = (abs_r > abs_l) ? abs_r : abs_l;
   assign inv_coef  = 25'h1000000 - 25'(coef_ff);
   assign dly_sample = ch_ff ? ram_rd_data[2*VW-1:VW] : ram_rd_data[VW-1:0];
   assign log_lo    = lpl_pkg::log_tab({1'b0, norm_ff[22:19]});
   assign log_hi    = lpl_pkg::log_tab({1'b0, norm_ff[22:19]} + 5'd1);
   assign e_n       = e_ff[21:16];
   assign exp_lo    = lpl_pkg::exp_tab({1'b0, e_ff[15:12]});
   assign exp_hi    = lpl_pkg::exp_tab({1'b0, e_ff[15:12]} + 5'd1);

   // shared multiplier operand select
   always_comb begin
      case (state_ff)
         ST_MUL_XL: begin
            mul_a = MW'(xl_ff);
            mul_b = $signed(MW'(makeup_ff));
         end
         ST_MUL_XR: begin
            mul_a = MW'(xr_ff);
            mul_b = $signed(MW'(makeup_ff));
         end
         ST_MUL_BL: begin
            mul_a = MW'(sl_ff);
            mul_b = $signed(MW'(gain_l));
         end
         ST_MUL_BR: begin
            mul_a = MW'(sr_ff);
            mul_b = $signed(MW'(gain_r));
         end
         ST_ENV_A: begin
            mul_a = $signed(MW'(coef_ff));
            mul_b = $signed(MW'(env_ff));
         end
         ST_ENV_B: begin
            mul_a = $signed(MW'(inv_coef));
            mul_b = $signed(MW'(m5_ff));
         end
         ST_LOG_M: begin
            mul_a = $signed(MW'(log_hi - log_lo));
            mul_b = $signed(MW'(norm_ff[18:0]));
         end
         ST_EXP_E: begin
            mul_a = $signed(MW'(d_ff));
            mul_b = $signed(MW'(neg_slope));
         end
         ST_EXP_M: begin
            mul_a = $signed(MW'(exp_lo - exp_hi));
            mul_b = $signed(MW'(e_ff[11:0]));
         end
         ST_GAIN_A: begin
            mul_a = 26'sd62259;
            mul_b = $signed(MW'(gain_ff));
         end
         ST_GAIN_B: begin
            mul_a = 26'sd3277;
            mul_b = $signed(MW'(target_ff));
         end
         ST_DLY_M: begin
            mul_a = MW'(dly_sample);
            mul_b = $signed(MW'(gain_ff));
         end
         ST_SQ_M: begin
            mul_a = MW'(r_ff);
            mul_b = MW'(r_ff);
         end
         ST_CUBE_M: begin
            mul_a = MW'(r2_ff);
            mul_b = MW'(r_ff);
         end
         ST_CLIP_M: begin
            mul_a = MW'(r3_ff);
            mul_b = 26'sd9706;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // product post-processing
   assign prod_r12 = rnd_sh(prod_ff, 6'd12);
   assign prod_r15 = rnd_sh(prod_ff, 6'd15);
   assign prod_r16 = rnd_sh(prod_ff, 6'd16);
   assign env_sum  = (acc_ff + prod_ff + 52'sd8388608) >>> 24;
   assign gain_sum = (acc_ff + prod_ff + 52'sd32768) >>> 16;
   assign e_sum    = (prod_ff + 52'sd16384) >>> 15;
   assign log_val  = 21'({p_ff, 16'd0}) + 21'(log_lo) + 21'(prod_ff[31:19]);
   assign tgt0     = exp_lo - 17'(prod_ff[28:12]);
   assign y_wide   = PW'(r_ff) - prod_r16;

   always_comb begin
      if (prod_r15 > 52'sd524287) begin
         v_sat = 20'sh7FFFF;
      end else if (prod_r15 < -52'sd524288) begin
         v_sat = -20'sh80000;
      end else begin
         v_sat = prod_r15[VW-1:0];
      end
   end

   // soft clip, hard limit beyond 1.5, clamp to 16 bits
   always_comb begin
      if (r_ff < -21'sd49152) begin
         y_val = -16'sh8000;
      end else if (r_ff > 21'sd49152) begin
         y_val = 16'sh7FFF;
      end else if (y_wide > 52'sd32767) begin
         y_val = 16'sh7FFF;
      end else if (y_wide < -52'sd32768) begin
         y_val = -16'sh8000;
      end else begin
         y_val = y_wide[15:0];
      end
   end

   // write position advance
   always_comb begin
      if (delay_ff == 9'd0) begin
         len_eff = LW'(1);
      end else if (LW'(delay_ff) > MAX_LEN) begin
         len_eff = MAX_LEN;
      end else begin
         len_eff = LW'(delay_ff);
      end
   end
   assign pos_inc  = LW'(pos_ff) + LW'(1);
   assign pos_next = (pos_inc >= len_eff) ? '0 : pos_inc[AW-1:0];

   // delay memory ports
   assign ram_rd_en   = req_fire && enable_ff;
   assign ram_wr_en   = clr_busy_ff || (state_ff == ST_PEAK);
   assign ram_wr_addr = clr_busy_ff ? clr_addr_ff : pos_ff;
   assign ram_wr_data = clr_busy_ff ? '0 : {vr_ff, vl_ff};

   lpl_ram #(
      .WIDTH (2 * VW),
      .DEPTH (MAX_DELAY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (pos_ff),
      .rd_data (ram_rd_data)
   );

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      enable_in    = enable_ff;
      thr_in       = thr_ff;
      slope_in     = slope_ff;
      makeup_in    = makeup_ff;
      bal_in       = bal_ff;
      attack_in    = attack_ff;
      release_in   = release_ff;
      delay_in     = delay_ff;
      xl_in        = xl_ff;
      xr_in        = xr_ff;
      sl_in        = sl_ff;
      sr_in        = sr_ff;
      vl_in        = vl_ff;
      vr_in        = vr_ff;
      m5_in        = m5_ff;
      coef_in      = coef_ff;
      acc_in       = acc_ff;
      env_in       = env_ff;
      gain_in      = gain_ff;
      norm_in      = norm_ff;
      p_in         = p_ff;
      step_in      = step_ff;
      pass_in      = pass_ff;
      loge_in      = loge_ff;
      d_in         = d_ff;
      e_in         = e_ff;
      target_in    = target_ff;
      ch_in        = ch_ff;
      r_in         = r_ff;
      r2_in        = r2_ff;
      r3_in        = r3_ff;
      yl_in        = yl_ff;
      yr_in        = yr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      pos_in       = pos_ff;
      clr_busy_in  = clr_busy_ff;
      clr_addr_in  = clr_addr_ff;

      // drop a taken result
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // sweep the delay memory to zero
      if (clr_busy_ff) begin
         if (clr_addr_ff == LAST_ADDR) begin
            clr_busy_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + AW'(1);
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               xl_in = req_tdata[15:0];
               xr_in = req_tdata[31:16];
               if (enable_ff) begin
                  state_in = ST_MUL_XL;
               end else begin
                  yl_in    = req_tdata[15:0];
                  yr_in    = req_tdata[31:16];
                  state_in = ST_OUT;
               end
            end
         end
         ST_MUL_XL: state_in = ST_MUL_XR;
         ST_MUL_XR: begin
            sl_in    = prod_r12[20:0];
            state_in = ST_MUL_BL;
         end
         ST_MUL_BL: begin
            sr_in    = prod_r12[20:0];
            state_in = ST_MUL_BR;
         end
         ST_MUL_BR: begin
            vl_in    = v_sat;
            state_in = ST_WB_VR;
         end
         ST_WB_VR: begin
            vr_in    = v_sat;
            state_in = ST_PEAK;
         end
         ST_PEAK: begin
            m5_in    = {max_abs, 5'd0};
            coef_in  = ({max_abs, 5'd0} > {1'b0, env_ff}) ? attack_ff : release_ff;
            pos_in   = pos_next;
            state_in = ST_ENV_A;
         end
         ST_ENV_A: state_in = ST_ENV_B;
         ST_ENV_B: begin
            acc_in   = prod_ff;
            state_in = ST_ENV_W;
         end
         ST_ENV_W: begin
            env_in   = (env_sum > 52'sd16777215) ? 24'hFFFFFF : env_sum[23:0];
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if ((env_ff > thr_q) && slope_ff[15]) begin
               norm_in  = env_ff;
               p_in     = 5'd23;
               step_in  = '0;
               pass_in  = 1'b0;
               state_in = ST_NORM;
            end else begin
               target_in = lpl_pkg::UNITY_GAIN;
               state_in  = ST_GAIN_A;
            end
         end
         ST_NORM: begin
            // binary leading-zero search, one step a cycle
            case (step_ff)
               3'd0: begin
                  if (norm_ff[23:8] == 16'd0) begin
                     norm_in = {norm_ff[7:0], 16'd0};
                     p_in    = p_ff - 5'd16;
                  end
               end
               3'd1: begin
                  if (norm_ff[23:16] == 8'd0) begin
                     norm_in = {norm_ff[15:0], 8'd0};
                     p_in    = p_ff - 5'd8;
                  end
               end
               3'd2: begin
                  if (norm_ff[23:20] == 4'd0) begin
                     norm_in = {norm_ff[19:0], 4'd0};
                     p_in    = p_ff - 5'd4;
                  end
               end
               3'd3: begin
                  if (norm_ff[23:22] == 2'd0) begin
                     norm_in = {norm_ff[21:0], 2'd0};
                     p_in    = p_ff - 5'd2;
                  end
               end
               default: begin
                  if (!norm_ff[23]) begin
                     norm_in = {norm_ff[22:0], 1'b0};
                     p_in    = p_ff - 5'd1;
                  end
               end
            endcase
            step_in = step_ff + 3'd1;
            if (step_ff == NORM_LAST) begin
               state_in = ST_LOG_M;
            end
         end
         ST_LOG_M: state_in = ST_LOG_W;
         ST_LOG_W: begin
            if (!pass_ff) begin
               loge_in  = log_val;
               norm_in  = thr_q;
               p_in     = 5'd23;
               step_in  = '0;
               pass_in  = 1'b1;
               state_in = ST_NORM;
            end else begin
               d_in     = (loge_ff > log_val) ? loge_ff - log_val : '0;
               state_in = ST_EXP_E;
            end
         end
         ST_EXP_E: state_in = ST_EXP_EW;
         ST_EXP_EW: begin
            e_in     = e_sum[21:0];
            state_in = ST_EXP_M;
         end
         ST_EXP_M: state_in = ST_EXP_W;
         ST_EXP_W: begin
            target_in = (e_n > 6'd16) ? '0 : tgt0 >> e_n;
            state_in  = ST_GAIN_A;
         end
         ST_GAIN_A: state_in = ST_GAIN_B;
         ST_GAIN_B: begin
            acc_in   = prod_ff;
            state_in = ST_GAIN_W;
         end
         ST_GAIN_W: begin
            gain_in  = gain_sum[16:0];
            ch_in    = 1'b0;
            state_in = ST_DLY_M;
         end
         ST_DLY_M: state_in = ST_DLY_W;
         ST_DLY_W: begin
            r_in     = prod_r16[20:0];
            state_in = ST_SQ_M;
         end
         ST_SQ_M: state_in = ST_SQ_W;
         ST_SQ_W: begin
            r2_in    = prod_r15[18:0];
            state_in = ST_CUBE_M;
         end
         ST_CUBE_M: state_in = ST_CUBE_W;
         ST_CUBE_W: begin
            r3_in    = prod_r15[18:0];
            state_in = ST_CLIP_M;
         end
         ST_CLIP_M: state_in = ST_CLIP_W;
         ST_CLIP_W: begin
            if (!ch_ff) begin
               yl_in    = y_val;
               ch_in    = 1'b1;
               state_in = ST_DLY_M;
            end else begin
               yr_in    = y_val;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {yr_ff, yl_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // configuration writes
      if (csr_wr) begin
         case (csr_idx)
            lpl_pkg::CSR_ENABLE: begin
               enable_in = csr_pwdata[0];
               if (!csr_pwdata[0]) begin
                  env_in      = '0;
                  gain_in     = lpl_pkg::UNITY_GAIN;
                  pos_in      = '0;
                  clr_busy_in = 1'b1;
                  clr_addr_in = '0;
               end
            end
            lpl_pkg::CSR_THRESHOLD: thr_in     = csr_pwdata[15:0];
            lpl_pkg::CSR_SLOPE:     slope_in   = csr_pwdata[15:0];
            lpl_pkg::CSR_MAKEUP:    makeup_in  = csr_pwdata[15:0];
            lpl_pkg::CSR_BALANCE:   bal_in     = csr_pwdata[15:0];
            lpl_pkg::CSR_ATTACK:    attack_in  = csr_pwdata[23:0];
            lpl_pkg::CSR_RELEASE:   release_in = csr_pwdata[23:0];
            lpl_pkg::CSR_DELAY:     delay_in   = csr_pwdata[8:0];
            default: ;
         endcase
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         enable_ff    <= 1'b0;
         thr_ff       <= 16'd32393;
         slope_ff     <= -16'sd31130;
         makeup_ff    <= 16'd4096;
         bal_ff       <= '0;
         attack_ff    <= 24'd13622093;
         release_ff   <= 24'd16773721;
         delay_ff     <= 9'd240;
         env_ff       <= '0;
         gain_ff      <= lpl_pkg::UNITY_GAIN;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         step_ff      <= '0;
         pass_ff      <= 1'b0;
         ch_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         thr_ff       <= thr_in;
         slope_ff     <= slope_in;
         makeup_ff    <= makeup_in;
         bal_ff       <= bal_in;
         attack_ff    <= attack_in;
         release_ff   <= release_in;
         delay_ff     <= delay_in;
         env_ff       <= env_in;
         gain_ff      <= gain_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
         step_ff      <= step_in;
         pass_ff      <= pass_in;
         ch_ff        <= ch_in;
      end
      xl_ff       <= xl_in;
      xr_ff       <= xr_in;
      sl_ff       <= sl_in;
      sr_ff       <= sr_in;
      vl_ff       <= vl_in;
      vr_ff       <= vr_in;
      m5_ff       <= m5_in;
      coef_ff     <= coef_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      norm_ff     <= norm_in;
      p_ff        <= p_in;
      loge_ff     <= loge_in;
      d_ff        <= d_in;
      e_ff        <= e_in;
      target_ff   <= target_in;
      r_ff        <= r_in;
      r2_ff       <= r2_in;
      r3_ff       <= r3_in;
      yl_ff       <= yl_in;
      yr_ff       <= yr_in;
      rsp_data_ff <= rsp_data_in;
   end

   // checks
   `LPL_ASSERT_IMP(a_gain_max, clock, reset, 1'b1,
      gain_ff <= lpl_pkg::UNITY_GAIN, "gain above unity")
   `LPL_ASSERT_IMP(a_norm_nonzero, clock, reset, state_ff == ST_NORM,
      norm_ff != 24'd0, "normalizing zero")
   `LPL_ASSERT_IMP(a_clear_full, clock, reset, $fell(clr_busy_ff),
      $past(clr_addr_ff) == LAST_ADDR, "clear pass cut short")
   `LPL_ASSERT_IMP(a_rsp_load, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff) == ST_OUT, "result loaded outside output step")
   `LPL_ASSERT_NXT(a_busy_after_req, clock, reset, req_fire,
      state_ff != ST_IDLE, "request taken but sequencer idle")

endmodule

// File: tb/tb_lookahead_peak_limiter_top.sv
// Testbench for the stereo look-ahead peak limiter: drives stereo frames and APB writes,
// predicts every output frame bit for bit and compares it. Depends on lpl_pkg and the RTL.
module tb_lookahead_peak_limiter_top;

   localparam int DEPTH = 256;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // sample_left [15:0], sample_right [31:16]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // out_left [15:0], out_right [31:16]
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [lpl_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [lpl_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [lpl_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic        csr_pready;

   lookahead_peak_limiter_top u_dut (.*);

   // predictor copy of registers and state
   logic        lim_enable;
   logic [15:0] lim_threshold;
   logic [15:0] lim_slope;
   logic [15:0] lim_makeup;
   logic [15:0] lim_balance;
   logic [23:0] lim_attack;
   logic [23:0] lim_release;
   logic [8:0]  lim_delay;
   longint      env_q;
   longint      gain_q;
   longint      delay_mem [DEPTH][2];
   int          wr_pos;

   logic [31:0] expected_frames[$];
   int          mismatch_count;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          hold_cycles;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint round_shift(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint log2_q16(longint x);
      int p;
      longint m, frac, idx, rem, a, b;
      p = 0;
      for (int i = 0; i < 32; i++) if (x[i]) p = i;
      m = (p <= 23) ? (x << (23 - p)) : (x >> (p - 23));
      frac = m & 64'h7FFFFF;
      idx = frac >> 19;
      rem = frac & 64'h7FFFF;
      a = lpl_pkg::log_tab(idx[4:0]);
      b = lpl_pkg::log_tab(idx[4:0] + 5'd1);
      return (longint'(p) << 16) + a + (((b - a) * rem) >>> 19);
   endfunction

   task automatic clear_limiter_state();
      env_q = 0;
      gain_q = 65536;
      foreach (delay_mem[i, c]) delay_mem[i][c] = 0;
      wr_pos = 0;
   endtask

   function automatic void apply_register(lpl_pkg::csr_index_type idx, logic [31:0] val);
      case (idx)
         lpl_pkg::CSR_ENABLE: begin
            lim_enable = val[0];
            if (!val[0]) begin
               env_q = 0;
               gain_q = 65536;
               foreach (delay_mem[i, c]) delay_mem[i][c] = 0;
               wr_pos = 0;
            end
         end
         lpl_pkg::CSR_THRESHOLD: lim_threshold = val[15:0];
         lpl_pkg::CSR_SLOPE:     lim_slope = val[15:0];
         lpl_pkg::CSR_MAKEUP:    lim_makeup = val[15:0];
         lpl_pkg::CSR_BALANCE:   lim_balance = val[15:0];
         lpl_pkg::CSR_ATTACK:    lim_attack = val[23:0];
         lpl_pkg::CSR_RELEASE:   lim_release = val[23:0];
         lpl_pkg::CSR_DELAY:     lim_delay = val[8:0];
         default: ;
      endcase
   endfunction

   // compute the limited frame for one request and advance the state
   function automatic logic [31:0] limit_frame(logic [31:0] frame);
      longint scaled[2];
      longint x, s, g, bal, peak, m5, coef, thr, slope, target;
      longint d, e, n, f, idx, rem, ea, eb, len, pos, dly, r, r2, r3, y;
      logic [31:0] result;
      if (!lim_enable) return frame;
      bal = longint'($signed(lim_balance));
      peak = 0;
      for (int ch = 0; ch < 2; ch++) begin
         x = (ch == 0) ? longint'($signed(frame[15:0])) : longint'($signed(frame[31:16]));
         s = round_shift(x * longint'(lim_makeup), 12);
         g = 32768;
         if (ch == 0 && bal > 0) g = 32768 - bal;
         if (ch == 1 && bal < 0) g = 32768 + bal;
         s = clip(round_shift(s * g, 15), -524288, 524287);
         scaled[ch] = s;
         if ((s < 0 ? -s : s) > peak) peak = s < 0 ? -s : s;
      end
      // envelope follower
      m5 = peak << 5;
      coef = (m5 > env_q) ? longint'(lim_attack) : longint'(lim_release);
      env_q = (coef * env_q + ((longint'(1) << 24) - coef) * m5 + (longint'(1) << 23)) >> 24;
      if (env_q > 64'hFFFFFF) env_q = 64'hFFFFFF;
      // gain target from the log-domain ratio
      thr = (lim_threshold == 0) ? 1 : longint'(lim_threshold);
      thr = thr << 5;
      target = 65536;
      slope = longint'($signed(lim_slope));
      if (env_q > thr && slope < 0) begin
         d = log2_q16(env_q) - log2_q16(thr);
         if (d < 0) d = 0;
         e = (d * (-slope) + 16384) >> 15;
         n = e >> 16;
         if (n > 16) begin
            target = 0;
         end else begin
            f = e & 16'hFFFF;
            idx = f >> 12;
            rem = f & 12'hFFF;
            ea = lpl_pkg::exp_tab(idx[4:0]);
            eb = lpl_pkg::exp_tab(idx[4:0] + 5'd1);
            target = (ea - (((ea - eb) * rem) >>> 12)) >> n;
         end
      end
      gain_q = (62259 * gain_q + 3277 * target + 32768) >> 16;
      // delay line and soft clip
      len = lim_delay;
      if (len == 0) len = 1;
      if (len > DEPTH) len = DEPTH;
      pos = wr_pos;
      if (pos >= DEPTH) pos = 0;
      for (int ch = 0; ch < 2; ch++) begin
         dly = delay_mem[pos][ch];
         delay_mem[pos][ch] = scaled[ch];
         r = round_shift(dly * gain_q, 16);
         if (r < -49152) begin
            y = -32768;
         end else if (r > 49152) begin
            y = 32767;
         end else begin
            r2 = round_shift(r * r, 15);
            r3 = round_shift(r2 * r, 15);
            y = clip(r - round_shift(r3 * 9706, 16), -32768, 32767);
         end
         result[ch*16 +: 16] = y[15:0];
      end
      pos++;
      if (pos >= len) pos = 0;
      wr_pos = pos;
      return result;
   endfunction

   // receiver side: random stall or long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // compare each output frame with the oldest expectation
   always @(posedge clock) begin
      logic [31:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_frames.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected frame %h", rsp_tdata);
         end else begin
            want = expected_frames.pop_front();
            if (want[15:0] !== rsp_tdata[15:0] || want[31:16] !== rsp_tdata[31:16]) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("frame mismatch: left exp %h got %h, right exp %h got %h",
                     want[15:0], rsp_tdata[15:0], want[31:16], rsp_tdata[31:16]);
            end
         end
      end
   end

   task automatic send_frame(logic [15:0] left, logic [15:0] right);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {right, left};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_frames.push_back(limit_frame({right, left}));
      req_tvalid <= 1'b0;
      // let the drop of valid settle before the next request
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_register(lpl_pkg::csr_index_type idx, logic [31:0] val);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= lpl_pkg::CSR_ADDR_W'(4 * int'(idx));
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      apply_register(idx, val);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      // allow the clearing pass after disable
      repeat (DEPTH + 20) @(posedge clock);
   endtask

   function automatic logic [15:0] random_sample();
      case ($urandom_range(5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'($urandom_range(2000)) - 16'd1000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic run_frames(int count);
      for (int i = 0; i < count; i++) send_frame(random_sample(), random_sample());
   endtask

   task automatic test_passthrough();
      send_frame(16'h7FFF, 16'h8000);
      send_frame(16'h8000, 16'h7FFF);
      send_frame(16'h0000, 16'hFFFF);
      send_frame(16'h5555, 16'hAAAA);
      wait_drained();
   endtask

   task automatic test_directed();
      write_register(lpl_pkg::CSR_DELAY, 32'd4);
      write_register(lpl_pkg::CSR_MAKEUP, 32'hFFFF);
      write_register(lpl_pkg::CSR_ENABLE, 32'd1);
      // loud frames push the envelope far over threshold; extremes clip
      for (int i = 0; i < 8; i++) send_frame(16'h7FFF, 16'h8000);
      send_frame(16'h0000, 16'h0000);
      send_frame(16'h5555, 16'hAAAA);
      wait_drained();
      // zero threshold and most negative slope drive the target gain to zero
      write_register(lpl_pkg::CSR_THRESHOLD, 32'd0);
      write_register(lpl_pkg::CSR_SLOPE, 32'h8000);
      write_register(lpl_pkg::CSR_ATTACK, 32'd0);
      for (int i = 0; i < 4; i++) send_frame(16'h7FFF, 16'h7FFF);
      wait_drained();
      // non-negative slope keeps unity; delay zero acts as one
      write_register(lpl_pkg::CSR_SLOPE, 32'd0);
      write_register(lpl_pkg::CSR_DELAY, 32'd0);
      write_register(lpl_pkg::CSR_BALANCE, 32'h7FFF);
      for (int i = 0; i < 3; i++) send_frame(16'h4000, 16'hC000);
      wait_drained();
      // delay above depth saturates; shrink below write position afterwards
      write_register(lpl_pkg::CSR_DELAY, 32'h1FF);
      write_register(lpl_pkg::CSR_BALANCE, 32'h8000);
      for (int i = 0; i < 6; i++) send_frame(16'h2000, 16'hE000);
      wait_drained();
      write_register(lpl_pkg::CSR_DELAY, 32'd2);
      send_frame(16'h1234, 16'hFEDC);
      send_frame(16'h7FFF, 16'h8001);
      wait_drained();
   endtask

   task automatic test_random_settings();
      for (int phase = 0; phase < 9; phase++) begin
         write_register(lpl_pkg::CSR_THRESHOLD,
            (phase % 3 == 0) ? 32'd32768 : $urandom_range(32768, 1));
         write_register(lpl_pkg::CSR_SLOPE,
            (phase == 1) ? 32'h8000 : 32'(-$urandom_range(32768, 0)));
         write_register(lpl_pkg::CSR_MAKEUP,
            (phase == 2) ? 32'd0 : $urandom_range(65535));
         write_register(lpl_pkg::CSR_BALANCE, $urandom_range(65535));
         write_register(lpl_pkg::CSR_ATTACK,
            (phase == 3) ? 32'hFFFFFF : $urandom_range(24'hFFFFFF));
         write_register(lpl_pkg::CSR_RELEASE,
            (phase == 4) ? 32'd0 : $urandom_range(24'hFFFFFF));
         write_register(lpl_pkg::CSR_DELAY,
            (phase == 5) ? 32'd256 : $urandom_range(40, 1));
         if (phase == 6) begin
            write_register(lpl_pkg::CSR_ENABLE, 32'd0);
            run_frames(20);
            wait_drained();
            write_register(lpl_pkg::CSR_ENABLE, 32'd1);
         end
         run_frames(80);
         wait_drained();
      end
   endtask

   task automatic test_backpressure();
      hold_cycles <= 3000;
      run_frames(40);
      wait_drained();
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      hold_cycles = 0;
      mismatch_count = 0;
      send_idle_pct = 10;
      recv_idle_pct = 72;
      lim_enable = 1'b0;
      lim_threshold = 16'd32393;
      lim_slope = 16'(-31130);
      lim_makeup = 16'd4096;
      lim_balance = 16'd0;
      lim_attack = 24'd13622093;
      lim_release = 24'd16773721;
      lim_delay = 9'd240;
      clear_limiter_state();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      repeat (DEPTH + 20) @(posedge clock);

      test_passthrough();
      test_directed();
      test_random_settings();
      send_idle_pct = 72;
      recv_idle_pct = 10;
      test_random_settings();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_backpressure();
      wait_drained();

      if (mismatch_count == 0 && expected_frames.size() == 0)
         $display("lookahead_peak_limiter_top verification clean");
      else
         $display("lookahead_peak_limiter_top verification failed");
      $finish;
   end

   // end the run if the design hangs
   initial begin
      #20000000;
      $display("lookahead_peak_limiter_top verification failed");
      $finish;
   end

endmodule
